// ===== hdl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment closest points: shared types and constants
// Fixed widths of the coordinate path, the wide product path and the
// divider, plus the words that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int COORD_W = 20;               // Q10.10 coordinate
    localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
    localparam int SQ_W    = 2 * DIFF_W;       // product of two differences
    localparam int DOT_W   = SQ_W + 2;         // signed dot product
    localparam int MAG_W   = DOT_W - 1;        // dot product magnitude
    localparam int LO_W    = 22;               // low half of a split operand
    localparam int HI_W    = MAG_W - LO_W;     // high half of a split operand
    localparam int PP_W    = 2 * LO_W;         // partial product
    localparam int WP_W    = 2 * MAG_W + 2;    // wide product magnitude
    localparam int NUM_W   = WP_W + 2;         // signed wide numerator
    localparam int PF      = 16;               // fraction bits of s and t
    localparam int PARAM_W = PF + 1;           // s and t, 0 .. 1.0
    localparam int Q_W     = PARAM_W;          // quotient bits per divide
    localparam int DIV_W   = 104;              // divider dividend/divisor
    localparam int PRD_W   = DOT_W + PARAM_W + 1;   // b * s
    localparam int RN_W    = DOT_W + 2;        // ratio numerator
    localparam int LP_W    = DIFF_W + PARAM_W + 1;  // d * s
    localparam int THR_W   = 21;
    localparam int DIST_W  = 42;

    localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {PF{1'b0}}};
    localparam logic [PARAM_W-1:0] PARAM_ZERO = '0;
    localparam logic [LP_W-1:0]    ROUND_HALF = LP_W'(1) << (PF - 1);
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_start_z;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] first_end_z;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_start_z;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
        logic signed [COORD_W-1:0] second_end_z;
    } t_in_word;

    typedef struct packed {
        logic        [DIST_W-1:0]  distance_squared;
        logic signed [COORD_W-1:0] first_closest_x;
        logic signed [COORD_W-1:0] first_closest_y;
        logic signed [COORD_W-1:0] first_closest_z;
        logic signed [COORD_W-1:0] second_closest_x;
        logic signed [COORD_W-1:0] second_closest_y;
        logic signed [COORD_W-1:0] second_closest_z;
    } t_out_word;

    // Data carried alongside a query through the whole pipeline
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic [2:0][DIFF_W-1:0]  d1;
        logic [2:0][DIFF_W-1:0]  d2;
        logic [SQ_W-1:0]         a;
        logic [SQ_W-1:0]         e;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] f;
        logic                    deg1;
        logic                    deg2;
        logic [PARAM_W-1:0]      s_keep;
        logic [PARAM_W-1:0]      t_fix;
        logic                    q_is_t;
    } t_side;

    // Divide request: either a forced quotient or floor(num / den)
    typedef struct packed {
        logic               force_q;
        logic [PARAM_W-1:0] force_val;
        logic [DIV_W-1:0]   num;
        logic [DIV_W-1:0]   den;
    } t_div_req;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DOT_W-1:0] v);
        logic signed [DOT_W-1:0] m;
        m = v[DOT_W-1] ? -v : v;
        return m[MAG_W-1:0];
    endfunction

endpackage

// ===== hdl/segment_segment_closest_points_top.sv =====
// ----------------------------------------------------------------------------
// Segment-segment closest points, top level
// One query is taken in every clock cycle; busy stays low. Each result
// appears on o_result with o_done high for one cycle, after passing
// 6 front stages, two 17-stage dividers (one quotient bit per
// stage), 2 middle stages and 4 back stages. Results leave in query order
// and must be captured in that cycle. The threshold may be written at any
// time through the cfg channel, which is always ready, but takes effect
// cleanly only while no query is in flight.
// ----------------------------------------------------------------------------
module segment_segment_closest_points_top import ssc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_item,
    output logic             o_done,
    output t_out_word        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data
);

    logic [THR_W-1:0] r_thr;
    logic             front_v, mid_v, div1_v, div2_v;
    t_div_req         front_req, mid_req;
    t_side            front_side, div1_side, mid_side, div2_side;
    logic [PARAM_W-1:0] div1_q, div2_q;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    ssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_thr   (r_thr),
        .o_valid (front_v),
        .o_req   (front_req),
        .o_side  (front_side)
    );

    ssc_div u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .i_req   (front_req),
        .i_side  (front_side),
        .o_valid (div1_v),
        .o_q     (div1_q),
        .o_side  (div1_side)
    );

    ssc_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div1_v),
        .i_q     (div1_q),
        .i_side  (div1_side),
        .o_valid (mid_v),
        .o_req   (mid_req),
        .o_side  (mid_side)
    );

    ssc_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_v),
        .i_req   (mid_req),
        .i_side  (mid_side),
        .o_valid (div2_v),
        .o_q     (div2_q),
        .o_side  (div2_side)
    );

    ssc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div2_v),
        .i_q     (div2_q),
        .i_side  (div2_side),
        .o_done  (o_done),
        .o_out   (o_result)
    );

endmodule

// ===== hdl/ssc_div.sv =====
// ----------------------------------------------------------------------------
// Segment closest points: pipelined divider
// Restoring divide, one quotient bit per register stage, most significant
// bit first. A forced request skips the quotient and returns its value.
// ----------------------------------------------------------------------------
module ssc_div import ssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_div_req           i_req,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [PARAM_W-1:0] o_q,
    output t_side              o_side
);

    logic               r_v    [Q_W];
    logic [DIV_W-1:0]   r_rem  [Q_W];
    logic [DIV_W-1:0]   r_den  [Q_W];
    logic [Q_W-1:0]     r_q    [Q_W];
    logic               r_frc  [Q_W];
    logic [PARAM_W-1:0] r_fval [Q_W];
    t_side              r_side [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_step
        logic               v_in;
        logic [DIV_W-1:0]   rem_in;
        logic [DIV_W-1:0]   den_in;
        logic [DIV_W-1:0]   den_sh;
        logic [Q_W-1:0]     q_in;
        logic [Q_W-1:0]     n_q;
        logic               frc_in;
        logic [PARAM_W-1:0] fval_in;
        t_side              side_in;
        logic               take;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_req.num;
            assign den_in  = i_req.den;
            assign q_in    = '0;
            assign frc_in  = i_req.force_q;
            assign fval_in = i_req.force_val;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign rem_in  = r_rem[g-1];
            assign den_in  = r_den[g-1];
            assign q_in    = r_q[g-1];
            assign frc_in  = r_frc[g-1];
            assign fval_in = r_fval[g-1];
            assign side_in = r_side[g-1];
        end

        assign den_sh = den_in << (Q_W - 1 - g);
        assign take   = rem_in >= den_sh;

        always_comb begin
            n_q = q_in;
            n_q[Q_W-1-g] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= take ? rem_in - den_sh : rem_in;
            r_den[g]  <= den_in;
            r_q[g]    <= n_q;
            r_frc[g]  <= frc_in;
            r_fval[g] <= fval_in;
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_q     = r_frc[Q_W-1] ? r_fval[Q_W-1] : r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ===== hdl/ssc_front.sv =====
// ----------------------------------------------------------------------------
// Segment closest points: front section
// Differences, dot products, degeneracy flags, the split wide products of
// the unclamped solve and the setup of the first divide.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_word         i_item,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_valid,
    output t_div_req         o_req,
    output t_side            o_side
);

    logic [2:0][COORD_W-1:0] p1, q1, p2, q2;

    assign p1 = {i_item.first_start_z, i_item.first_start_y, i_item.first_start_x};
    assign q1 = {i_item.first_end_z, i_item.first_end_y, i_item.first_end_x};
    assign p2 = {i_item.second_start_z, i_item.second_start_y, i_item.second_start_x};
    assign q2 = {i_item.second_end_z, i_item.second_end_y, i_item.second_end_x};

    // Stage 1: differences
    logic                   r1_v;
    t_side                  r1_side;
    logic [2:0][DIFF_W-1:0] r1_r;
    t_side                  n1_side;
    logic [2:0][DIFF_W-1:0] n1_r;

    always_comb begin
        n1_side = '0;
        n1_side.p1 = p1;
        n1_side.p2 = p2;
        for (int k = 0; k < 3; k++) begin
            n1_side.d1[k] = DIFF_W'($signed(q1[k])) - DIFF_W'($signed(p1[k]));
            n1_side.d2[k] = DIFF_W'($signed(q2[k])) - DIFF_W'($signed(p2[k]));
            n1_r[k]       = DIFF_W'($signed(p1[k])) - DIFF_W'($signed(p2[k]));
        end
    end

    // Stage 2: per-axis products
    logic                 r2_v;
    t_side                r2_side;
    logic [2:0][SQ_W-1:0] r2_aa, r2_ee, r2_bb, r2_cc, r2_ff;
    logic [2:0][SQ_W-1:0] n2_aa, n2_ee, n2_bb, n2_cc, n2_ff;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_aa[k] = $signed(r1_side.d1[k]) * $signed(r1_side.d1[k]);
            n2_ee[k] = $signed(r1_side.d2[k]) * $signed(r1_side.d2[k]);
            n2_bb[k] = $signed(r1_side.d1[k]) * $signed(r1_side.d2[k]);
            n2_cc[k] = $signed(r1_side.d1[k]) * $signed(r1_r[k]);
            n2_ff[k] = $signed(r1_side.d2[k]) * $signed(r1_r[k]);
        end
    end

    // Stage 3: dot products
    logic  r3_v;
    t_side r3_side;
    t_side n3_side;

    always_comb begin
        n3_side = r2_side;
        n3_side.a = r2_aa[0] + r2_aa[1] + r2_aa[2];
        n3_side.e = r2_ee[0] + r2_ee[1] + r2_ee[2];
        n3_side.b = DOT_W'($signed(r2_bb[0])) + DOT_W'($signed(r2_bb[1]))
                  + DOT_W'($signed(r2_bb[2]));
        n3_side.c = DOT_W'($signed(r2_cc[0])) + DOT_W'($signed(r2_cc[1]))
                  + DOT_W'($signed(r2_cc[2]));
        n3_side.f = DOT_W'($signed(r2_ff[0])) + DOT_W'($signed(r2_ff[1]))
                  + DOT_W'($signed(r2_ff[2]));
    end

    // Stage 4: degeneracy and split partial products of a*e, b*b, b*f, c*e
    logic                      r4_v;
    t_side                     r4_side;
    logic [3:0][3:0][PP_W-1:0] r4_pp;
    t_side                     n4_side;
    logic [3:0][3:0][PP_W-1:0] n4_pp;
    logic [3:0][MAG_W-1:0]     mx, my;

    always_comb begin
        n4_side = r3_side;
        n4_side.deg1 = r3_side.a <= SQ_W'(i_thr);
        n4_side.deg2 = r3_side.e <= SQ_W'(i_thr);
        mx[0] = MAG_W'(r3_side.a);
        my[0] = MAG_W'(r3_side.e);
        mx[1] = mag_of(r3_side.b);
        my[1] = mag_of(r3_side.b);
        mx[2] = mag_of(r3_side.b);
        my[2] = mag_of(r3_side.f);
        mx[3] = mag_of(r3_side.c);
        my[3] = MAG_W'(r3_side.e);
        for (int m = 0; m < 4; m++) begin
            n4_pp[m][0] = PP_W'(mx[m][LO_W-1:0]) * PP_W'(my[m][LO_W-1:0]);
            n4_pp[m][1] = PP_W'(mx[m][LO_W-1:0]) * PP_W'(my[m][MAG_W-1:LO_W]);
            n4_pp[m][2] = PP_W'(mx[m][MAG_W-1:LO_W]) * PP_W'(my[m][LO_W-1:0]);
            n4_pp[m][3] = PP_W'(mx[m][MAG_W-1:LO_W]) * PP_W'(my[m][MAG_W-1:LO_W]);
        end
    end

    // Stage 5: recombine partial products
    logic                  r5_v;
    t_side                 r5_side;
    logic [3:0][WP_W-1:0]  r5_wp;
    logic [3:0][WP_W-1:0]  n5_wp;

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            n5_wp[m] = WP_W'(r4_pp[m][0])
                     + (WP_W'(r4_pp[m][1]) << LO_W)
                     + (WP_W'(r4_pp[m][2]) << LO_W)
                     + (WP_W'(r4_pp[m][3]) << (2 * LO_W));
        end
    end

    // Stage 6: s numerator and denominator, clamp or set up the divide
    logic                    neg_bf, neg_ce;
    logic [WP_W-1:0]         den6;
    logic signed [NUM_W-1:0] sbf, sce, num6;
    t_div_req                n6_req;

    always_comb begin
        neg_bf = r5_side.b[DOT_W-1] ^ r5_side.f[DOT_W-1];
        neg_ce = r5_side.c[DOT_W-1];
        den6   = (r5_wp[0] > r5_wp[1]) ? r5_wp[0] - r5_wp[1] : '0;
        sbf    = neg_bf ? -NUM_W'(r5_wp[2]) : NUM_W'(r5_wp[2]);
        sce    = neg_ce ? -NUM_W'(r5_wp[3]) : NUM_W'(r5_wp[3]);
        num6   = sbf - sce;
        n6_req = '0;
        n6_req.num = DIV_W'($unsigned(num6)) << PF;
        n6_req.den = DIV_W'(den6);
        if (den6 == '0 || num6[NUM_W-1] || num6 == '0) begin
            n6_req.force_q   = 1'b1;
            n6_req.force_val = PARAM_ZERO;
        end else if ($unsigned(num6) >= NUM_W'(den6)) begin
            n6_req.force_q   = 1'b1;
            n6_req.force_val = PARAM_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            o_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= n1_side;
        r1_r    <= n1_r;
        r2_side <= r1_side;
        r2_aa   <= n2_aa;
        r2_ee   <= n2_ee;
        r2_bb   <= n2_bb;
        r2_cc   <= n2_cc;
        r2_ff   <= n2_ff;
        r3_side <= n3_side;
        r4_side <= n4_side;
        r4_pp   <= n4_pp;
        r5_side <= r4_side;
        r5_wp   <= n5_wp;
        o_side  <= r5_side;
        o_req   <= n6_req;
    end

endmodule

// ===== hdl/ssc_mid.sv =====
// ----------------------------------------------------------------------------
// Segment closest points: middle section
// Checks t against [0,1] with the quantized s and sets up the second
// divide: t itself, or a recomputed s once t is clamped or pinned to zero.
// ----------------------------------------------------------------------------
module ssc_mid import ssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PARAM_W-1:0] i_q,
    input  t_side              i_side,
    output logic               o_valid,
    output t_div_req           o_req,
    output t_side              o_side
);

    // Stage 1: b * s
    logic                    r1_v;
    t_side                   r1_side;
    logic signed [PRD_W-1:0] r1_prod;
    t_side                   n1_side;

    always_comb begin
        n1_side = i_side;
        n1_side.s_keep = i_q;
    end

    // Stage 2: t numerator and selection of the second divide
    logic signed [PRD_W-1:0] tn;
    logic [PRD_W-1:0]        e_sh;
    logic signed [RN_W-1:0]  rn;
    logic [SQ_W-1:0]         rd;
    logic                    use_ratio;
    t_side                   n2_side;
    t_div_req                n2_req;

    always_comb begin
        tn        = r1_prod + (PRD_W'(r1_side.f) <<< PF);
        e_sh      = PRD_W'(r1_side.e) << PF;
        n2_side   = r1_side;
        n2_req    = '0;
        use_ratio = 1'b1;
        rn        = -RN_W'(r1_side.c);
        rd        = r1_side.a;
        n2_side.t_fix  = PARAM_ZERO;
        n2_side.q_is_t = 1'b0;
        if (r1_side.deg1 && r1_side.deg2) begin
            rn = '0;
        end else if (r1_side.deg1) begin
            n2_side.s_keep = PARAM_ZERO;
            n2_side.q_is_t = 1'b1;
            rn = RN_W'(r1_side.f);
            rd = r1_side.e;
        end else if (r1_side.deg2) begin
            rn = -RN_W'(r1_side.c);
        end else if (tn[PRD_W-1]) begin
            rn = -RN_W'(r1_side.c);
        end else if ($unsigned(tn) > e_sh) begin
            n2_side.t_fix = PARAM_ONE;
            rn = RN_W'(r1_side.b) - RN_W'(r1_side.c);
        end else begin
            use_ratio      = 1'b0;
            n2_side.q_is_t = 1'b1;
        end

        if (use_ratio) begin
            n2_req.num = DIV_W'($unsigned(rn)) << PF;
            n2_req.den = DIV_W'(rd);
            if (rn[RN_W-1] || rn == '0) begin
                n2_req.force_q   = 1'b1;
                n2_req.force_val = PARAM_ZERO;
            end else if ($unsigned(rn) >= RN_W'(rd)) begin
                n2_req.force_q   = 1'b1;
                n2_req.force_val = PARAM_ONE;
            end
        end else begin
            n2_req.num = DIV_W'($unsigned(tn));
            n2_req.den = DIV_W'(r1_side.e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r1_v    <= i_valid;
            o_valid <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= n1_side;
        r1_prod <= $signed(i_side.b) * $signed({1'b0, i_q});
        o_side  <= n2_side;
        o_req   <= n2_req;
    end

endmodule

// ===== hdl/ssc_back.sv =====
// ----------------------------------------------------------------------------
// Segment closest points: back section
// Final s and t, interpolated closest points with round to nearest, and
// the squared distance between them.
// ----------------------------------------------------------------------------
module ssc_back import ssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PARAM_W-1:0] i_q,
    input  t_side              i_side,
    output logic               o_done,
    output t_out_word          o_out
);

    // Stage 1: pick s and t, scale the directions
    logic                    r1_v;
    logic [PARAM_W-1:0]      r1_s, r1_t;
    logic                    r1_deg1, r1_deg2;
    logic [2:0][COORD_W-1:0] r1_p1, r1_p2;
    logic [2:0][LP_W-1:0]    r1_m1, r1_m2;
    logic [PARAM_W-1:0]      s_sel, t_sel;
    logic [2:0][LP_W-1:0]    n1_m1, n1_m2;

    always_comb begin
        s_sel = i_side.q_is_t ? i_side.s_keep : i_q;
        t_sel = i_side.q_is_t ? i_q : i_side.t_fix;
        for (int k = 0; k < 3; k++) begin
            n1_m1[k] = $signed(i_side.d1[k]) * $signed({1'b0, s_sel});
            n1_m2[k] = $signed(i_side.d2[k]) * $signed({1'b0, t_sel});
        end
    end

    // Stage 2: round and add to the start points
    logic                    r2_v;
    logic [2:0][COORD_W-1:0] r2_c1, r2_c2;
    logic [2:0][COORD_W-1:0] n2_c1, n2_c2;
    logic [2:0][LP_W-1:0]    h1, h2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            h1[k]    = r1_m1[k] + ROUND_HALF;
            h2[k]    = r1_m2[k] + ROUND_HALF;
            n2_c1[k] = COORD_W'($signed(r1_p1[k]) + $signed(h1[k][LP_W-1:PF]));
            n2_c2[k] = COORD_W'($signed(r1_p2[k]) + $signed(h2[k][LP_W-1:PF]));
        end
    end

    // Stage 3: per-axis squared gaps
    logic                    r3_v;
    logic [2:0][COORD_W-1:0] r3_c1, r3_c2;
    logic [2:0][SQ_W-1:0]    r3_sq;
    logic [2:0][DIFF_W-1:0]  dd;
    logic [2:0][SQ_W-1:0]    n3_sq;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dd[k]    = DIFF_W'($signed(r2_c1[k])) - DIFF_W'($signed(r2_c2[k]));
            n3_sq[k] = $signed(dd[k]) * $signed(dd[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r1_v   <= i_valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            o_done <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_s    <= s_sel;
        r1_t    <= t_sel;
        r1_deg1 <= i_side.deg1;
        r1_deg2 <= i_side.deg2;
        r1_p1   <= i_side.p1;
        r1_p2   <= i_side.p2;
        r1_m1   <= n1_m1;
        r1_m2   <= n1_m2;
        r2_c1   <= n2_c1;
        r2_c2   <= n2_c2;
        r3_c1   <= r2_c1;
        r3_c2   <= r2_c2;
        r3_sq   <= n3_sq;
        o_out.distance_squared <= r3_sq[0] + r3_sq[1] + r3_sq[2];
        o_out.first_closest_x  <= $signed(r3_c1[0]);
        o_out.first_closest_y  <= $signed(r3_c1[1]);
        o_out.first_closest_z  <= $signed(r3_c1[2]);
        o_out.second_closest_x <= $signed(r3_c2[0]);
        o_out.second_closest_y <= $signed(r3_c2[1]);
        o_out.second_closest_z <= $signed(r3_c2[2]);
    end

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v |-> (r1_s <= PARAM_ONE) && (r1_t <= PARAM_ONE))
        else $error("segment parameter above one");

    a_deg1_s_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && r1_deg1 |-> r1_s == PARAM_ZERO)
        else $error("degenerate first segment with nonzero s");

    a_deg2_t_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && r1_deg2 |-> r1_t == PARAM_ZERO)
        else $error("degenerate second segment with nonzero t");

    a_zero_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.first_closest_x == o_out.second_closest_x)
               && (o_out.first_closest_y == o_out.second_closest_y)
               && (o_out.first_closest_z == o_out.second_closest_z)
        |-> o_out.distance_squared == '0)
        else $error("coincident closest points with nonzero distance");

endmodule

// ===== tb/segment_segment_closest_points_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment closest points, testbench
// Queries go in through start/busy, and the degeneracy threshold is
// written while the pipeline is empty. Each query is predicted here with
// exact wide integer arithmetic. Each o_done word is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_segment_closest_points_top_tb;
    import ssc_pkg::*;

    localparam int SETTLE      = 60;       // pipeline is 46 deep
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {W_QUERY, W_THRESH, W_DRAIN} t_word_kind;
    typedef struct {
        t_word_kind       kind;
        t_in_word         seg;
        logic [THR_W-1:0] thr;
    } t_stim_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_word         i_item = '0;
    logic             o_done;
    t_out_word        o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data = '0;

    t_stim_word stim_q[$];
    t_out_word  closest_q[$];
    logic [THR_W-1:0] thr_shadow = THR_RESET;
    int quiet_cycles = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int burst_left = 8;
    int gap_left = 0;

    segment_segment_closest_points_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // n/d clamped to [0,1] as Q1.16; d > 0
    function automatic logic [PARAM_W-1:0] clamp_ratio(logic signed [127:0] n,
                                                       logic signed [127:0] d);
        if (n <= 0) return PARAM_ZERO;
        if (n >= d) return PARAM_ONE;
        return PARAM_W'((n <<< PF) / d);
    endfunction

    function automatic t_out_word closest_points(t_in_word w, logic [THR_W-1:0] thr);
        longint p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3], c1[3], c2[3];
        longint a, e, b, c, f, s, t, dd, dist_sum;
        logic signed [127:0] wa, we, wb, wc, wf, ws, den, tn;
        t_out_word res;
        p1 = '{w.first_start_x, w.first_start_y, w.first_start_z};
        q1 = '{w.first_end_x, w.first_end_y, w.first_end_z};
        p2 = '{w.second_start_x, w.second_start_y, w.second_start_z};
        q2 = '{w.second_end_x, w.second_end_y, w.second_end_z};
        a = 0; e = 0; b = 0; c = 0; f = 0; s = 0; t = 0; dist_sum = 0;
        for (int k = 0; k < 3; k++) begin
            d1[k] = q1[k] - p1[k];
            d2[k] = q2[k] - p2[k];
            r[k]  = p1[k] - p2[k];
        end
        for (int k = 0; k < 3; k++) begin
            a += d1[k] * d1[k];
            e += d2[k] * d2[k];
            b += d1[k] * d2[k];
            c += d1[k] * r[k];
            f += d2[k] * r[k];
        end
        wa = a; we = e; wb = b; wc = c; wf = f;
        if (a <= longint'(thr) && e <= longint'(thr)) begin
            s = 0; t = 0;
        end else if (a <= longint'(thr)) begin
            t = clamp_ratio(wf, we);
        end else if (e <= longint'(thr)) begin
            s = clamp_ratio(-wc, wa);
        end else begin
            den = wa * we - wb * wb;
            // parallel: no unique solution, pin s to the start
            s = (den > 0) ? clamp_ratio(wb * wf - wc * we, den) : 0;
            ws = s;
            tn = wb * ws + (wf <<< PF);
            if (tn < 0) begin
                t = 0;
                s = clamp_ratio(-wc, wa);
            end else if (tn > (we <<< PF)) begin
                t = PARAM_ONE;
                s = clamp_ratio(wb - wc, wa);
            end else begin
                t = longint'(tn / we);
            end
        end
        for (int k = 0; k < 3; k++) begin
            // round to nearest, ties up
            c1[k] = p1[k] + ((d1[k] * s + (longint'(1) << (PF - 1))) >>> PF);
            c2[k] = p2[k] + ((d2[k] * t + (longint'(1) << (PF - 1))) >>> PF);
            dd = c1[k] - c2[k];
            dist_sum += dd * dd;
        end
        res.distance_squared = dist_sum[DIST_W-1:0];
        res.first_closest_x  = c1[0][COORD_W-1:0];
        res.first_closest_y  = c1[1][COORD_W-1:0];
        res.first_closest_z  = c1[2][COORD_W-1:0];
        res.second_closest_x = c2[0][COORD_W-1:0];
        res.second_closest_y = c2[1][COORD_W-1:0];
        res.second_closest_z = c2[2][COORD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, field,
                 got, want);
        mismatches++;
    endtask

    // Driver: bursts of query words with random gaps; threshold writes and
    // drain points wait for an empty pipeline
    always @(posedge i_clk) begin : driver
        logic next_start, next_cfg;
        next_start = 1'b0;
        next_cfg = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    W_QUERY: begin
                        i_item <= stim_q[0].seg;
                        next_start = 1'b1;
                        void'(stim_q.pop_front());
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0
                                       : $urandom_range(1, 10);
                        end
                    end
                    W_THRESH: begin
                        if (!start && !i_cfg_valid && quiet_cycles >= SETTLE) begin
                            i_cfg_data <= stim_q[0].thr;
                            next_cfg = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        if (!start && !i_cfg_valid && quiet_cycles >= 1)
                            void'(stim_q.pop_front());
                    end
                endcase
            end
            start <= next_start;
            i_cfg_valid <= next_cfg;
        end
    end

    // Monitor: predict on accept, check on done
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        logic accept;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        accept = i_rst_n && start && !busy;
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            thr_shadow = i_cfg_data;
        if (accept)
            closest_q.push_back(closest_points(i_item, thr_shadow));
        if (i_rst_n && o_done) begin
            if (closest_q.size() == 0) begin
                report_mismatch("unexpected word", o_result.distance_squared, 0);
            end else begin
                want = closest_q.pop_front();
                if (o_result.distance_squared !== want.distance_squared)
                    report_mismatch("distance_squared", o_result.distance_squared,
                                    want.distance_squared);
                if (o_result.first_closest_x !== want.first_closest_x)
                    report_mismatch("first_closest_x", o_result.first_closest_x,
                                    want.first_closest_x);
                if (o_result.first_closest_y !== want.first_closest_y)
                    report_mismatch("first_closest_y", o_result.first_closest_y,
                                    want.first_closest_y);
                if (o_result.first_closest_z !== want.first_closest_z)
                    report_mismatch("first_closest_z", o_result.first_closest_z,
                                    want.first_closest_z);
                if (o_result.second_closest_x !== want.second_closest_x)
                    report_mismatch("second_closest_x", o_result.second_closest_x,
                                    want.second_closest_x);
                if (o_result.second_closest_y !== want.second_closest_y)
                    report_mismatch("second_closest_y", o_result.second_closest_y,
                                    want.second_closest_y);
                if (o_result.second_closest_z !== want.second_closest_z)
                    report_mismatch("second_closest_z", o_result.second_closest_z,
                                    want.second_closest_z);
            end
        end
        if (accept || closest_q.size() > 0 || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [COORD_W-1:0] coord(int span);
        if (span == 0) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic add_query(t_in_word w);
        stim_q.push_back('{W_QUERY, w, '0});
    endtask

    task automatic add_thresh(logic [THR_W-1:0] thr);
        stim_q.push_back('{W_THRESH, '0, thr});
    endtask

    function automatic t_in_word random_segments();
        t_in_word w;
        int span, k;
        span = ($urandom_range(0, 1) == 0) ? 4096 : 65536;
        w = '{coord(span), coord(span), coord(span), coord(span), coord(span),
              coord(span), coord(span), coord(span), coord(span), coord(span),
              coord(span), coord(span)};
        case ($urandom_range(0, 9))
            0, 1: w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, 16'($urandom)});
            2: begin    // first nearly a point
                w.first_end_x = w.first_start_x + coord(1);
                w.first_end_y = w.first_start_y + coord(1);
                w.first_end_z = w.first_start_z + coord(1);
            end
            3: begin    // second nearly a point
                w.second_end_x = w.second_start_x + coord(1);
                w.second_end_y = w.second_start_y + coord(1);
                w.second_end_z = w.second_start_z + coord(1);
            end
            4, 5: begin // parallel or antiparallel
                k = $urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3);
                w.second_end_x = w.second_start_x + k * (w.first_end_x - w.first_start_x);
                w.second_end_y = w.second_start_y + k * (w.first_end_y - w.first_start_y);
                w.second_end_z = w.second_start_z + k * (w.first_end_z - w.first_start_z);
            end
            6: begin    // shared start point
                w.second_start_x = w.first_start_x;
                w.second_start_y = w.first_start_y;
                w.second_start_z = w.first_start_z;
            end
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [THR_W-1:0] phase_thr [5];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset threshold
        add_query('0);
        add_query({12{20'sh7FFFF}});
        add_query({12{20'sh80000}});
        add_query('{-524288, -524288, -524288, 524287, 524287, 524287,
                    524287, -524288, 524287, -524288, 524287, -524288});
        add_query('{1024, 0, 0, 1024, 0, 0, 0, -1024, 0, 0, 1024, 0});
        add_query('{-1024, 0, 0, 1024, 0, 0, 0, 2048, 0, 0, 2048, 0});
        add_query('{0, 0, 0, 2048, 0, 0, 0, 1024, 0, 2048, 1024, 0});
        add_query('{0, 0, 0, 2048, 0, 0, 3072, 1024, 0, 1024, 1024, 0});
        add_query('{-1024, 0, 0, 1024, 0, 0, 0, -1024, 512, 0, 1024, 512});
        add_query('{0, 0, 0, 1024, 0, 0, -3072, 1024, 0, -2048, 3072, 0});
        add_query('{0, 0, 0, 1024, 0, 0, 2048, -4096, 0, 3072, -2048, 0});
        add_query('{0, 0, 0, 3, 0, 0, 1, 5, 0, 2, 9, 0});
        add_query('{0, 0, 0, 1, 0, 0, 0, 3, 0, 0, 1, 0});
        add_query('{524287, -524288, 524287, -524288, 524287, -524288,
                    -524288, 524287, -524288, 524287, -524288, 524287});
        add_thresh('0);
        add_query('0);
        add_query('{0, 0, 0, 1, 0, 0, 0, 3, 0, 0, 1, 0});
        add_query('{0, 0, 0, 2048, 0, 0, 0, 1024, 0, 2048, 1024, 0});
        add_thresh(21'd1048576);
        add_query('{0, 0, 0, 1024, 0, 0, 0, 512, 0, 0, 1536, 0});
        add_query('{0, 0, 0, 1025, 0, 0, 0, 512, 0, 0, 1536, 0});
        add_thresh('1);
        add_query('{0, 0, 0, 1448, 0, 0, 0, 512, 0, 3000, 512, 0});
        add_query({12{20'sh7FFFF}});

        // random phases over several thresholds
        phase_thr = '{21'd1, 21'd0, 21'd1048576, 21'($urandom_range(0, 1048576)), '1};
        for (int ph = 0; ph < 5; ph++) begin
            add_thresh(phase_thr[ph]);
            for (int n = 0; n < 186; n++) begin
                if (ph == 2 && n == 90)
                    stim_q.push_back('{W_DRAIN, '0, '0});
                add_query(random_segments());
            end
        end

        while (stim_q.size() > 0 || start || quiet_cycles < SETTLE)
            @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
